>>> src/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg: shared types and constants for the wildcard glob matcher
// Holds the wildcard byte codes, the op code of an input beat and the
// structs that run between the top level and the row of position cells.
// ----------------------------------------------------------------------------
package wgm_pkg;

  // Wildcard bytes
  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  // Op field of an input beat
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic       clr;      // a new pattern starts: drop the stored one
    logic       wr;       // store wr_byte at the first free cell
    logic [7:0] wr_byte;
    logic       wr_star;  // wr_byte is a star
    logic       consume;  // text byte: advance the position set
    logic [7:0] sym;      // the text byte
    logic       restart;  // reload the position set from position zero
    logic       capture;  // latch the end-position hit for a verdict
  } wgm_ctrl_t;

  // Neighbor link from cell i to cell i+1
  typedef struct packed {
    logic head;      // receiver is position zero
    logic zero;      // sender is position zero
    logic used_eff;  // sender holds a byte (after a pattern clear)
    logic gate_nxt;  // sender will hold a star after this beat
    logic step;      // sender moves its active bit forward on this byte
    logic raw;       // sender's position set entry before star skipping
    logic gate;      // sender holds a star now
  } wgm_link_t;

  // Per-cell status seen by the top level
  typedef struct packed {
    logic active;
    logic used;
    logic hit;
  } wgm_stat_t;

endpackage

>>> src/wgm_cell.sv
// ----------------------------------------------------------------------------
// wgm_cell: one pattern position of the matcher
// Stores one pattern byte and the active bit of its position. Each beat it
// takes the step and skip terms of its left neighbor and hands its own on,
// so the row updates the whole position set on each beat. Runs of stars are
// merged on load, so a star skip never reaches past one neighbor.
// ----------------------------------------------------------------------------
module wgm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  wgm_pkg::wgm_ctrl_t ctrl_i,
  input  wgm_pkg::wgm_link_t lnk_i,
  output wgm_pkg::wgm_link_t lnk_o,
  output wgm_pkg::wgm_stat_t stat_o
);
  import wgm_pkg::*;

  logic [7:0] byte_r, byte_nxt;
  logic       star_r, star_nxt;
  logic       used_r, used_nxt;
  logic       active_r, active_nxt;
  logic       hit_r, hit_nxt;

  logic used_eff;
  logic wr_here;
  logic sym_hit;
  logic keep;
  logic step;
  logic raw;
  logic closed;
  logic act_rst;

  // Pattern load: the write token sits at the first free cell
  always_comb begin
    used_eff = used_r & ~ctrl_i.clr;
    wr_here  = ctrl_i.wr & lnk_i.used_eff & ~used_eff;
    byte_nxt = wr_here ? ctrl_i.wr_byte : byte_r;
    star_nxt = wr_here ? ctrl_i.wr_star : star_r;
    used_nxt = used_eff | wr_here;
  end

  // Text step: a star holds its position, other bytes advance on a hit
  always_comb begin
    sym_hit = (byte_r == ctrl_i.sym) | (byte_r == QMARK_BYTE);
    keep    = active_r & used_r & star_r;
    step    = active_r & used_r & ~star_r & sym_hit;
    raw     = keep | lnk_i.step;
    closed  = raw | (lnk_i.raw & lnk_i.gate);
    // restart: position zero, plus position one behind a leading star
    act_rst = lnk_i.head | (lnk_i.zero & lnk_i.gate_nxt);
  end

  // Next active bit and verdict capture
  always_comb begin
    if (ctrl_i.restart) begin
      active_nxt = act_rst;
    end else if (ctrl_i.consume) begin
      active_nxt = closed;
    end else begin
      active_nxt = active_r;
    end
    if (ctrl_i.capture) begin
      hit_nxt = (ctrl_i.consume ? closed : active_r) & ~used_r;
    end else begin
      hit_nxt = hit_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    star_r <= star_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= 1'b0;
      active_r <= lnk_i.head;
      hit_r    <= 1'b0;
    end else begin
      used_r   <= used_nxt;
      active_r <= active_nxt;
      hit_r    <= hit_nxt;
    end
  end

  // Hand-off to the right neighbor
  always_comb begin
    lnk_o.head     = 1'b0;
    lnk_o.zero     = lnk_i.head;
    lnk_o.used_eff = used_eff;
    lnk_o.gate_nxt = used_nxt & star_nxt;
    lnk_o.step     = step;
    lnk_o.raw      = raw;
    lnk_o.gate     = used_r & star_r;
  end

  assign stat_o.active = active_r;
  assign stat_o.used   = used_r;
  assign stat_o.hit    = hit_r;

endmodule

>>> src/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher: whole-string '?' / '*' glob match
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  op, symbol, has_symbol, last
//   out_     out  out_valid/out_stall matched, pattern_error
//
// One beat per cycle on the input while in_stall is low, pattern and text alike; the row of
// PAT_MAX+1 position cells updates the whole position set in that cycle.
// A verdict for a closing text beat is registered in the cells' hit bits and the
// hold stage, then the end-position OR goes into the output register.
// Reset loads an empty, closed pattern; no clearing pass.
// in_stall rises only when a verdict waits in the hold stage and the output
// register is full and stalled.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher #(
  parameter int PAT_MAX = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_symbol,
  input  logic       in_has_symbol,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_pattern_error
);
  import wgm_pkg::*;

  localparam int CW = $clog2(PAT_MAX + 1);

  logic          complete_r, complete_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          last_star_r, last_star_nxt;
  logic          pend_r, pend_nxt;
  logic          pend_err_r, pend_err_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_matched_r, out_matched_nxt;
  logic          out_error_r, out_error_nxt;

  logic          acc;
  logic          pat;
  logic          txt;
  logic          is_star;
  logic          move;
  logic [CW-1:0] cnt_eff;
  logic          ovf_eff;
  logic          ls_eff;
  wgm_ctrl_t     ctrl;

  wgm_link_t     lnk [0:PAT_MAX+1];
  wgm_stat_t     stat [0:PAT_MAX];
  logic [PAT_MAX:0] act_v;
  logic [PAT_MAX:0] used_v;
  logic [PAT_MAX:0] hit_v;

  // Input handshake
  assign in_stall = pend_r & out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign pat      = acc & (in_op == OP_PATTERN);
  assign txt      = acc & (in_op == OP_TEXT) & complete_r;
  assign is_star  = (in_symbol == STAR_BYTE);

  // Pattern bookkeeping and cell control
  always_comb begin
    ctrl          = '0;
    ctrl.clr      = pat & complete_r;
    cnt_eff       = ctrl.clr ? '0 : cnt_r;
    ovf_eff       = ctrl.clr ? 1'b0 : ovf_r;
    ls_eff        = ctrl.clr ? 1'b0 : last_star_r;
    cnt_nxt       = cnt_eff;
    ovf_nxt       = ovf_eff;
    last_star_nxt = ls_eff;
    complete_nxt  = ctrl.clr ? 1'b0 : complete_r;
    ctrl.wr_byte  = in_symbol;
    ctrl.wr_star  = is_star;
    ctrl.sym      = in_symbol;
    if (pat && in_has_symbol) begin
      if (cnt_eff < CW'(PAT_MAX)) begin
        cnt_nxt       = cnt_eff + CW'(1);
        // a star right after a star adds nothing; keep one
        ctrl.wr       = ~(is_star & ls_eff);
        last_star_nxt = is_star;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (pat && in_last) begin
      complete_nxt = 1'b1;
    end
    ctrl.consume = txt & in_has_symbol;
    ctrl.capture = txt & in_last;
    ctrl.restart = (pat & in_last) | (txt & in_last);
  end

  // Row of position cells
  assign lnk[0].head     = 1'b1;
  assign lnk[0].zero     = 1'b0;
  assign lnk[0].used_eff = 1'b1;
  assign lnk[0].gate_nxt = 1'b0;
  assign lnk[0].step     = 1'b0;
  assign lnk[0].raw      = 1'b0;
  assign lnk[0].gate     = 1'b0;

  for (genvar i = 0; i <= PAT_MAX; i++) begin : g_cell
    wgm_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl),
      .lnk_i  (lnk[i]),
      .lnk_o  (lnk[i+1]),
      .stat_o (stat[i])
    );
    assign act_v[i]  = stat[i].active;
    assign used_v[i] = stat[i].used;
    assign hit_v[i]  = stat[i].hit;
  end

  // Verdict hold stage and output register
  always_comb begin
    move            = pend_r & (~out_valid_r | ~out_stall);
    pend_nxt        = ctrl.capture | (pend_r & ~move);
    pend_err_nxt    = ctrl.capture ? ovf_r : pend_err_r;
    out_valid_nxt   = move | (out_valid_r & out_stall);
    out_matched_nxt = out_matched_r;
    out_error_nxt   = out_error_r;
    if (move) begin
      out_matched_nxt = ~pend_err_r & (|hit_v);
      out_error_nxt   = pend_err_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    last_star_r   <= last_star_nxt;
    pend_err_r    <= pend_err_nxt;
    out_matched_r <= out_matched_nxt;
    out_error_r   <= out_error_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complete_r  <= 1'b1;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      complete_r  <= complete_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_matched       = out_matched_r;
  assign out_pattern_error = out_error_r;

  // Checks
  // with a closed pattern only the end position may be active past it;
  // while a pattern loads, bits left from an abandoned text linger
  a_end_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    complete_r |-> $onehot0(act_v & ~used_v))
    else $error("more than one active position past the pattern end");

  // the spare cell past PAT_MAX never takes a byte
  a_spare_free: assert property (@(posedge clk) disable iff (!rst_n)
    !lnk[PAT_MAX+1].used_eff)
    else $error("pattern byte written past PAT_MAX");

  // a restart leaves position zero active
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.restart |=> act_v[0])
    else $error("position zero inactive after restart");

  // an overflowed pattern never reports a match
  a_err_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_matched_r && out_error_r))
    else $error("match reported with pattern error");

endmodule

>>> tb/sv/wildcard_glob_matcher_test.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_test: self-checking bench for the glob matcher
// Loads patterns of '*', '?' and literal bytes, then streams texts that are
// built from each pattern, bent at random or fully random. Each verdict is
// checked against a position-set tracker kept in the bench. Both channels
// idle and stall in random bursts.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_test;
  import wgm_pkg::*;

  localparam int PAT_MAX   = 64;
  localparam int N_BEATS   = 1250;
  localparam int CALM_TAIL = 150;
  localparam int MAX_CYCLES = 500000;

  typedef struct packed {
    logic       op;
    logic [7:0] sym;
    logic       has;
    logic       last;
    logic       hold;  // wait for every verdict before this beat
  } beat_t;

  typedef struct packed {
    logic matched;
    logic perr;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_op = OP_PATTERN;
  logic [7:0] in_symbol = 8'h00;
  logic       in_has_symbol = 1'b0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_matched;
  logic       out_pattern_error;

  beat_t      beats_pending[$];
  verdict_t   verdicts_due[$];
  logic [7:0] pat_plan[$];

  // Tracker state: stored pattern and the reachable position set
  logic [7:0]       pat_mem[PAT_MAX];
  int               pat_len = 0;
  bit               pat_closed = 1'b1;
  bit               pat_over = 1'b0;
  bit [PAT_MAX:0]   reach = {{PAT_MAX{1'b0}}, 1'b1};

  int beats_total = 0;
  int beats_sent = 0;
  int beats_taken = 0;
  int text_dropped = 0;
  int n_verdicts = 0;
  int n_hits = 0;
  int n_perr = 0;
  int fails = 0;
  int cycles = 0;
  int gap_left = 0;
  int idle_pct = 20;
  int stall_left = 0;
  int stall_pct = 20;
  bit calm;

  wildcard_glob_matcher #(.PAT_MAX(PAT_MAX)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_symbol        (in_symbol),
    .in_has_symbol    (in_has_symbol),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_matched      (out_matched),
    .out_pattern_error(out_pattern_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign calm = (beats_sent >= beats_total - CALM_TAIL);

  // ---------------------------------------------------------------- tracker
  // A star lets its position be skipped, so the set stays closed over stars
  function automatic void spread_stars();
    for (int i = 0; i < pat_len; i++)
      if (reach[i] && pat_mem[i] == STAR_BYTE) reach[i + 1] = 1'b1;
  endfunction

  function automatic void restart_reach();
    reach = '0;
    reach[0] = 1'b1;
    spread_stars();
  endfunction

  function automatic void advance_reach(logic [7:0] c);
    bit [PAT_MAX:0] moved;
    moved = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (reach[i]) begin
        if (pat_mem[i] == STAR_BYTE) moved[i] = 1'b1;
        else if (pat_mem[i] == QMARK_BYTE || pat_mem[i] == c) moved[i + 1] = 1'b1;
      end
    end
    reach = moved;
    spread_stars();
  endfunction

  function automatic void track_beat(logic op, logic [7:0] sym, logic has, logic last);
    verdict_t v;
    if (op == OP_PATTERN) begin
      // first beat of a new pattern drops the old one
      if (pat_closed) begin
        pat_len = 0;
        pat_over = 1'b0;
        pat_closed = 1'b0;
      end
      if (has) begin
        if (pat_len < PAT_MAX) begin
          pat_mem[pat_len] = sym;
          pat_len++;
        end else begin
          pat_over = 1'b1;
        end
      end
      if (last) begin
        pat_closed = 1'b1;
        restart_reach();
      end
    end else if (!pat_closed) begin
      text_dropped++;
    end else begin
      if (has) advance_reach(sym);
      if (last) begin
        v.perr = pat_over;
        v.matched = pat_over ? 1'b0 : reach[pat_len];
        verdicts_due.push_back(v);
        restart_reach();
      end
    end
  endfunction

  // -------------------------------------------------------------- stimulus
  task automatic add_beat(logic op, logic [7:0] sym, logic has, logic last, logic hold = 1'b0);
    beat_t b;
    b.op = op;
    b.sym = sym;
    b.has = has;
    b.last = last;
    b.hold = hold;
    beats_pending.push_back(b);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 7))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'h00;
      2:       return 8'hFF;
      default: return 8'("a" + $urandom_range(0, 2));
    endcase
  endfunction

  function automatic logic [7:0] pick_pat_byte();
    case ($urandom_range(0, 9))
      0, 1:    return STAR_BYTE;
      2, 3:    return QMARK_BYTE;
      default: return pick_letter();
    endcase
  endfunction

  // Pattern beats, with ignored text and empty beats mixed in
  task automatic gen_pattern(int len, logic hold);
    bit sep_close;
    logic [7:0] b;
    pat_plan.delete();
    sep_close = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 14) == 0)
        add_beat(OP_TEXT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), hold && i == 0);
      if ($urandom_range(0, 14) == 0)
        add_beat(OP_PATTERN, 8'($urandom_range(0, 255)), 1'b0, 1'b0, hold && i == 0);
      b = pick_pat_byte();
      pat_plan.push_back(b);
      add_beat(OP_PATTERN, b, 1'b1, !sep_close && i == len - 1, hold && i == 0);
    end
    if (sep_close)
      add_beat(OP_PATTERN, 8'($urandom_range(0, 255)), 1'b0, 1'b1, hold && len == 0);
  endtask

  // One text, mostly shaped to fit the current pattern, then bent or not
  task automatic gen_text();
    logic [7:0] txt[$];
    int k;
    bit sep_end;
    foreach (pat_plan[i]) begin
      if (pat_plan[i] == STAR_BYTE) begin
        repeat ($urandom_range(0, 3)) txt.push_back(pick_letter());
      end else if (pat_plan[i] == QMARK_BYTE) begin
        txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        txt.push_back(pat_plan[i]);
      end
    end
    case ($urandom_range(0, 11))
      0: if (txt.size() != 0) txt[$urandom_range(0, txt.size() - 1)] = pick_letter();
      1: if (txt.size() != 0) txt.delete($urandom_range(0, txt.size() - 1));
      2: txt.insert($urandom_range(0, txt.size()), pick_letter());
      3: begin
        txt.delete();
        repeat ($urandom_range(0, 6)) txt.push_back(pick_letter());
      end
      default: ;
    endcase
    sep_end = (txt.size() == 0) || ($urandom_range(0, 4) == 0);
    k = 0;
    foreach (txt[i]) begin
      if ($urandom_range(0, 11) == 0)
        add_beat(OP_TEXT, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_beat(OP_TEXT, txt[i], 1'b1, !sep_end && k == txt.size() - 1);
      k++;
    end
    if (sep_end) add_beat(OP_TEXT, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    int ep;
    int r;
    // directed: empty pattern out of reset
    add_beat(OP_TEXT, 8'h00, 1'b0, 1'b1);
    add_beat(OP_TEXT, "a", 1'b1, 1'b1);
    // pattern 00 * ? FF, with a text beat while it is still open
    add_beat(OP_PATTERN, 8'h00, 1'b1, 1'b0);
    add_beat(OP_TEXT, 8'hFF, 1'b1, 1'b1);
    add_beat(OP_PATTERN, STAR_BYTE, 1'b1, 1'b0);
    add_beat(OP_PATTERN, QMARK_BYTE, 1'b1, 1'b0);
    add_beat(OP_PATTERN, 8'hFF, 1'b1, 1'b1);
    // star eats one byte, byteless beat in the middle
    add_beat(OP_TEXT, 8'h00, 1'b1, 1'b0);
    add_beat(OP_TEXT, 8'h5A, 1'b0, 1'b0);
    add_beat(OP_TEXT, 8'h11, 1'b1, 1'b0);
    add_beat(OP_TEXT, 8'h22, 1'b1, 1'b0);
    add_beat(OP_TEXT, 8'hFF, 1'b1, 1'b1);
    // too short for the question mark
    add_beat(OP_TEXT, 8'h00, 1'b1, 1'b0);
    add_beat(OP_TEXT, 8'hFF, 1'b1, 1'b1);
    // star matches nothing
    add_beat(OP_TEXT, 8'h00, 1'b1, 1'b0);
    add_beat(OP_TEXT, 8'hFF, 1'b1, 1'b0);
    add_beat(OP_TEXT, 8'hFF, 1'b1, 1'b1);
    // text left open, then an explicit empty pattern
    add_beat(OP_TEXT, "q", 1'b1, 1'b0);
    add_beat(OP_PATTERN, 8'hA5, 1'b0, 1'b1);
    add_beat(OP_TEXT, "x", 1'b1, 1'b1);
    add_beat(OP_TEXT, 8'h00, 1'b0, 1'b1);

    // random episodes: one pattern, a few texts, some noise
    pat_plan.delete();
    ep = 0;
    while (beats_pending.size() < N_BEATS) begin
      r = $urandom_range(0, 19);
      if (ep == 0) len = PAT_MAX;
      else if (ep == 1) len = PAT_MAX + 1;
      else if (r == 0) len = $urandom_range(PAT_MAX - 2, PAT_MAX + 4);
      else if (r == 1) len = 0;
      else len = $urandom_range(1, 8);
      gen_pattern(len, ep == 2 || $urandom_range(0, 24) == 0);
      repeat ($urandom_range(1, 4)) gen_text();
      // abandoned text, dropped by the next pattern
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) add_beat(OP_TEXT, pick_letter(), 1'b1, 1'b0);
      ep++;
    end
    // close with a text so the tail yields a verdict
    gen_text();
    beats_total = beats_pending.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_pending.size() != 0 || in_valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d beats (%0d text beats ignored while a pattern was open),",
             beats_sent, text_dropped);
    $display("checked %0d verdicts: %0d matches, %0d pattern overflows",
             n_verdicts, n_hits, n_perr);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive
    beat_t nxt;
    bit go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_beat(in_op, in_symbol, in_has_symbol, in_last);
        beats_taken++;
      end
      // a stalled beat stays put
      if (!(in_valid && in_stall)) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (beats_pending.size() != 0 &&
                     !(beats_pending[0].hold && verdicts_due.size() != 0)) begin
          go = 1'b1;
        end
        if (go) begin
          nxt = beats_pending.pop_front();
          in_op <= nxt.op;
          in_symbol <= nxt.sym;
          in_has_symbol <= nxt.has;
          in_last <= nxt.last;
          beats_sent++;
          if (beats_sent % 80 == 0) begin
            case ($urandom_range(0, 2))
              0:       idle_pct = 0;
              1:       idle_pct = 15;
              default: idle_pct = 40;
            endcase
          end
          if (!calm && $urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 5);
        end
        in_valid <= go;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_verdicts++;
        if (out_matched) n_hits++;
        if (out_pattern_error) n_perr++;
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, got matched=%0b error=%0b",
                   $time, out_matched, out_pattern_error);
          fails++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_matched !== want.matched) begin
            $display("%0t: matched mismatch, expected %0b, got %0b",
                     $time, want.matched, out_matched);
            fails++;
          end
          if (out_pattern_error !== want.perr) begin
            $display("%0t: pattern_error mismatch, expected %0b, got %0b",
                     $time, want.perr, out_pattern_error);
            fails++;
          end
        end
        if (n_verdicts % 16 == 0) stall_pct = $urandom_range(0, 2) * 20;
      end
      // random stall bursts
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycles, verdicts_due.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule

>>> wildcard_glob_matcher.f
src/wgm_pkg.sv
src/wgm_cell.sv
src/wildcard_glob_matcher.sv
tb/sv/wildcard_glob_matcher_test.sv
